/* hdl/tla_pkg.sv */
package tla_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VAL_W      = FRAC_BITS + 1;
    localparam int PROD_W     = 2 * VAL_W - 1;
    localparam int SUM_W      = 45;
    localparam int WPROD_W    = SUM_W + VAL_W;
    localparam int DEN_W      = SUM_W + 2;
    localparam int DERIV_W    = 32;
    localparam int RES_W      = DERIV_W + 1;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 1;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [VAL_W-1:0] UNIT_VAL      = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] WEIGHT_RESET  = VAL_W'(1) << (FRAC_BITS - 1);
    localparam logic [SUM_W-1:0] SUM_LIMIT     = '1;
    localparam logic [RES_W-1:0] DERIV_CAP     = RES_W'(1) << (DERIV_W - 1);

    localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(FRAC_BITS);
    localparam logic [CNT_W-1:0] RATIO_LAST = CNT_W'(FRAC_BITS);
    localparam logic [CNT_W-1:0] ROUND_STEP = CNT_W'(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] DIV1_LAST  = CNT_W'(3 * FRAC_BITS);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(3 * FRAC_BITS + 1);

    localparam logic [IDX_W-1:0] REG_FP_WEIGHT = 1'b0;
    localparam logic [IDX_W-1:0] REG_FN_WEIGHT = 1'b1;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_FLUSH,
        ST_LOAD,
        ST_MUL,
        ST_DEN_A,
        ST_DEN_B,
        ST_DIV,
        ST_DONE
    } tla_state_t;

    typedef struct packed {
        logic accept;
        logic mul_load;
        logic mul_step;
        logic den_a;
        logic den_b;
        logic div1_en;
        logic div1_first;
        logic div2_en;
        logic ratio_shift;
        logic ratio_round;
        logic load_out;
    } tla_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic out_free;
    } tla_status_t;

    function automatic logic [VAL_W-1:0] clamp_unit(input logic [VAL_W-1:0] v);
        return (v > UNIT_VAL) ? UNIT_VAL : v;
    endfunction

endpackage

/* hdl/tla_ctrl.sv */
module tla_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tlast,
    output logic               s_axis_tready,
    input  tla_pkg::tla_status_t status,
    output tla_pkg::tla_cmd_t    cmd
);
    import tla_pkg::*;

    tla_state_t       state_reg;
    tla_state_t       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                if (s_axis_tvalid && s_axis_tlast)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_MUL;
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                    state_next = ST_DEN_A;
            end
            ST_DEN_A: state_next = ST_DEN_B;
            ST_DEN_B: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.den_zero || cnt_reg == DIV_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_ACC;
            end
            default:  state_next = ST_ACC;
        endcase
    end

    always_comb
    begin
        if ((state_reg == ST_MUL || state_reg == ST_DIV) && state_next == state_reg)
            cnt_next = cnt_reg + CNT_W'(1);
        else
            cnt_next = '0;
    end

    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                s_axis_tready = 1'b1;
                cmd.accept    = s_axis_tvalid;
            end
            ST_FLUSH: ;
            ST_LOAD:  cmd.mul_load = 1'b1;
            ST_MUL:   cmd.mul_step = 1'b1;
            ST_DEN_A: cmd.den_a    = 1'b1;
            ST_DEN_B: cmd.den_b    = 1'b1;
            ST_DIV:
            begin
                if (!status.den_zero)
                begin
                    cmd.div1_en     = (cnt_reg <= DIV1_LAST);
                    cmd.div1_first  = (cnt_reg == '0);
                    cmd.div2_en     = (cnt_reg != '0);
                    cmd.ratio_shift = (cnt_reg <= RATIO_LAST);
                    cmd.ratio_round = (cnt_reg == ROUND_STEP);
                end
            end
            ST_DONE:  cmd.load_out = status.out_free;
            default: ;
        endcase
    end

    a_load_returns: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> state_reg == ST_ACC)
        else $error("result load did not return to accumulation");

    a_mul_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == MUL_LAST) |=> state_reg == ST_DEN_A)
        else $error("weight multiply ran past its step count");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> cnt_reg <= DIV_LAST)
        else $error("divide step count out of range");

endmodule

/* hdl/tla_datapath.sv */
module tla_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [tla_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                cfg_we,
    input  logic [tla_pkg::IDX_W-1:0]           cfg_index,
    input  logic [tla_pkg::VAL_W-1:0]           cfg_data,
    input  tla_pkg::tla_cmd_t                   cmd,
    output tla_pkg::tla_status_t                status,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [tla_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser
);
    import tla_pkg::*;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [PROD_W-1:0] v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(v);
        return (t > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : t[SUM_W-1:0];
    endfunction

    logic [VAL_W-1:0]   fp_weight_reg;
    logic [VAL_W-1:0]   fn_weight_reg;

    logic [VAL_W-1:0]   y;
    logic [VAL_W-1:0]   p;
    logic               prod_valid_reg;
    logic [PROD_W-1:0]  tp_prod_reg;
    logic [PROD_W-1:0]  fp_prod_reg;
    logic [PROD_W-1:0]  fn_prod_reg;
    logic [SUM_W-1:0]   tp_sum_reg;
    logic [SUM_W-1:0]   fp_sum_reg;
    logic [SUM_W-1:0]   fn_sum_reg;

    logic [VAL_W-1:0]   ma_reg;
    logic [VAL_W-1:0]   mb_reg;
    logic [WPROD_W-1:0] fp_sh_reg;
    logic [WPROD_W-1:0] fn_sh_reg;
    logic [WPROD_W-1:0] pa_reg;
    logic [WPROD_W-1:0] pb_reg;

    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   r1_reg;
    logic [DEN_W-1:0]   r2_reg;
    logic               bit1_reg;
    logic [VAL_W-1:0]   ratio_reg;
    logic [RES_W-1:0]   res_reg;
    logic               sat_reg;

    logic [DEN_W:0]     cand1;
    logic [DEN_W:0]     diff1;
    logic               ge1;
    logic [DEN_W:0]     cand2;
    logic [DEN_W:0]     diff2;
    logic               ge2;
    logic [RES_W-1:0]   res_next;
    logic [DERIV_W-1:0] mag;

    logic               out_valid_reg;
    logic [VAL_W-1:0]   out_loss_reg;
    logic [DERIV_W-1:0] out_deriv_reg;
    logic               out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_weight_reg <= WEIGHT_RESET;
            fn_weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FP_WEIGHT: fp_weight_reg <= cfg_data;
                REG_FN_WEIGHT: fn_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign y = clamp_unit(s_axis_tdata[VAL_W-1:0]);
    assign p = clamp_unit(s_axis_tdata[2*VAL_W-1:VAL_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else
            prod_valid_reg <= cmd.accept;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tp_prod_reg <= PROD_W'(y) * PROD_W'(p);
            fp_prod_reg <= PROD_W'(UNIT_VAL - y) * PROD_W'(p);
            fn_prod_reg <= PROD_W'(y) * PROD_W'(UNIT_VAL - p);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_sum_reg <= '0;
            fp_sum_reg <= '0;
            fn_sum_reg <= '0;
        end
        else if (cmd.mul_load)
        begin
            tp_sum_reg <= '0;
            fp_sum_reg <= '0;
            fn_sum_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            tp_sum_reg <= sat_add(tp_sum_reg, tp_prod_reg);
            fp_sum_reg <= sat_add(fp_sum_reg, fp_prod_reg);
            fn_sum_reg <= sat_add(fn_sum_reg, fn_prod_reg);
        end
    end

    // shift-add weight multiply, one weight bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            ma_reg    <= clamp_unit(fp_weight_reg);
            mb_reg    <= clamp_unit(fn_weight_reg);
            fp_sh_reg <= WPROD_W'(fp_sum_reg);
            fn_sh_reg <= WPROD_W'(fn_sum_reg);
            pa_reg    <= '0;
            pb_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (ma_reg[0])
                pa_reg <= pa_reg + fp_sh_reg;
            if (mb_reg[0])
                pb_reg <= pb_reg + fn_sh_reg;
            fp_sh_reg <= fp_sh_reg << 1;
            fn_sh_reg <= fn_sh_reg << 1;
            ma_reg    <= ma_reg >> 1;
            mb_reg    <= mb_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.den_a)
            den_reg <= r1_reg + DEN_W'(pa_reg[WPROD_W-1:FRAC_BITS]);
        else if (cmd.den_b)
            den_reg <= den_reg + DEN_W'(pb_reg[WPROD_W-1:FRAC_BITS]);
    end

    assign cand1 = cmd.div1_first ? {1'b0, r1_reg} : {r1_reg, 1'b0};
    assign diff1 = cand1 - {1'b0, den_reg};
    assign ge1   = (cand1 >= {1'b0, den_reg});

    assign cand2 = {r2_reg, bit1_reg};
    assign diff2 = cand2 - {1'b0, den_reg};
    assign ge2   = (cand2 >= {1'b0, den_reg});

    assign res_next = {res_reg[RES_W-2:0], ge2};

    // first divider feeds quotient bits of TP/den; second divides that stream by den again
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            r1_reg    <= DEN_W'(tp_sum_reg);
            r2_reg    <= '0;
            bit1_reg  <= 1'b0;
            ratio_reg <= '0;
            res_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.div1_en)
            begin
                r1_reg   <= ge1 ? diff1[DEN_W-1:0] : cand1[DEN_W-1:0];
                bit1_reg <= ge1;
            end
            if (cmd.ratio_shift)
                ratio_reg <= {ratio_reg[VAL_W-2:0], ge1};
            else if (cmd.ratio_round)
                ratio_reg <= ratio_reg + VAL_W'(ge1);
            if (cmd.div2_en)
            begin
                r2_reg <= ge2 ? diff2[DEN_W-1:0] : cand2[DEN_W-1:0];
                if (!sat_reg)
                begin
                    res_reg <= res_next;
                    if (res_next > DERIV_CAP)
                        sat_reg <= 1'b1;
                end
            end
        end
    end

    assign mag = sat_reg ? DERIV_CAP[DERIV_W-1:0] : res_reg[DERIV_W-1:0];

    assign status.den_zero = (den_reg == '0);
    assign status.out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= status.den_zero;
            if (status.den_zero)
            begin
                out_loss_reg  <= '0;
                out_deriv_reg <= '0;
            end
            else
            begin
                out_loss_reg  <= UNIT_VAL - ratio_reg;
                out_deriv_reg <= DERIV_W'(RES_W'(0) - RES_W'(mag));
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {(OUT_DATA_W - DERIV_W - VAL_W)'(0), out_deriv_reg, out_loss_reg};

    a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_load |-> !prod_valid_reg)
        else $error("sums captured while a product was still pending");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div1_en |-> den_reg != '0)
        else $error("divide step with zero denominator");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg) |-> (out_loss_reg == '0 && out_deriv_reg == '0))
        else $error("zero denominator result carries nonzero fields");

    a_loss_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_status_reg) |-> out_loss_reg <= UNIT_VAL)
        else $error("loss above one");

    a_deriv_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_deriv_reg[DERIV_W-1] || out_deriv_reg == '0))
        else $error("derivative positive");

endmodule

/* hdl/tversky_loss_accumulator.sv */
// Accepts one (truth, prediction) beat per cycle while accumulating a vector.
// After the beat marked tlast the block runs a flush, a load, the shift-add weight
// multiply, 2 denominator adds, the bit-serial divide steps and an output load;
// a zero denominator skips the divide. No beat is accepted again until the output
// load, which waits while the output register still holds an unaccepted result.
// rst_n clears the sums and control, and sets both weights to 0.5.
module tversky_loss_accumulator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // truth_value [16:0], predicted_value [33:17], zero [39:34]
    input  logic [tla_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // loss_value [16:0], derivative_value [48:17], zero [55:49]
    output logic [tla_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status_code [0]
    output logic                               m_axis_tuser,
    input  logic                               cfg_we,
    input  logic [tla_pkg::IDX_W-1:0]          cfg_index,
    input  logic [tla_pkg::VAL_W-1:0]          cfg_data
);
    import tla_pkg::*;

    tla_cmd_t    cmd;
    tla_status_t status;

    tla_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    tla_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
